/* hdl/cec_pkg.sv */
// ============================================================================
// cec_pkg: shared constants and tables for the calendar epoch clock
// Calendar constants, the reciprocal used to divide a year by 100,
// the tick period reset value and the cumulative month length table.
// ============================================================================
`default_nettype none

package cec_pkg;

  localparam int YEAR_W   = 14;
  localparam int PERIOD_W = 30;
  localparam int NSEC_W   = 30;
  localparam int TIME_W   = 64;

  // Multiplier operand and product widths of the shared unit.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 30;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [PERIOD_W-1:0] TICK_RESET = PERIOD_W'(100000000);

  localparam int EPOCH_YEAR         = 1970;
  localparam int DAYS_PER_YEAR      = 365;
  localparam int LEAPS_BEFORE_EPOCH = 1969 / 4 - 1969 / 100 + 1969 / 400;
  localparam int SEC_PER_DAY        = 86400;
  localparam int SEC_PER_HOUR       = 3600;
  localparam int SEC_PER_MIN        = 60;
  localparam int NS_PER_SEC         = 1000000000;

  // y / 100 == (y * DIV100_MUL) >> DIV100_SHIFT for every 14-bit y.
  localparam int DIV100_MUL   = 41944;
  localparam int DIV100_SHIFT = 22;
  localparam int Q100_W       = 8;

  // Days in all months before month index n (n full months, 0..12).
  function automatic logic [8:0] cum_days(input logic [3:0] n);
    logic [8:0] d;
    unique case (n)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/calendar_epoch_clock.sv */
// ============================================================================
// calendar_epoch_clock: 64-bit nanosecond clock loaded from a calendar date
// Converts a calendar date and time to nanoseconds since 1970-01-01 on a
// load beat and advances by a programmable period on a tick beat.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_ready): in_func = 0 loads the clock from the
//   date and time fields, in_func = 1 adds the tick period. Every input beat
//   yields exactly one output beat (out_valid / out_ready) carrying the clock
//   value after the update in out_time_ns.
//   A load passes the states DIV, DAYS, SLO, SHI, SACC, NLO, NHI and NACC:
//   one 32x30 multiplier is reused for the divide-by-100 of the year and
//   for the two-half scaling by 86400 and by 10^9, with a register after
//   each product. A tick goes straight to the output state. in_ready is high
//   only while the sequencer is idle, so one item is in flight at a time and
//   a new one is accepted only once the last has left the sequencer.
//   The result sits in an output register; the next item is accepted while
//   it waits, and a finished result only holds in the sequencer if the
//   previous one has not yet been taken.
//   cfg_wr_en writes cfg_wr_data into the tick period at once.
//   Reset (rst_n low, synchronous) clears the clock to zero, sets the tick
//   period to 100 ms and drops out_valid.
// ============================================================================
`default_nettype none

module calendar_epoch_clock
  import cec_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_func,
  input  wire logic [YEAR_W-1:0]   in_year,
  input  wire logic [3:0]          in_month,
  input  wire logic [4:0]          in_day_of_month,
  input  wire logic [4:0]          in_hour,
  input  wire logic [5:0]          in_minute,
  input  wire logic [5:0]          in_second,
  input  wire logic [NSEC_W-1:0]   in_nanosecond,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [TIME_W-1:0]        out_time_ns,
  input  wire logic                cfg_wr_en,
  input  wire logic [PERIOD_W-1:0] cfg_wr_data
);

  // Sequencer state codes.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV  = 4'd1;
  localparam logic [3:0] ST_DAYS = 4'd2;
  localparam logic [3:0] ST_SLO  = 4'd3;
  localparam logic [3:0] ST_SHI  = 4'd4;
  localparam logic [3:0] ST_SACC = 4'd5;
  localparam logic [3:0] ST_NLO  = 4'd6;
  localparam logic [3:0] ST_NHI  = 4'd7;
  localparam logic [3:0] ST_NACC = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]          state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]   clock_r, clock_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [TIME_W-1:0]   acc_r, acc_nxt;
  logic [TIME_W-1:0]   x_r, x_nxt;
  logic [MUL_P_W-1:0]  prod_r, prod_nxt;

  // Captured load fields.
  logic [YEAR_W-1:0]   year_r;
  logic [3:0]          month_r;
  logic [4:0]          mday_r;
  logic [4:0]          hour_r;
  logic [5:0]          minute_r;
  logic [5:0]          second_r;
  logic [NSEC_W-1:0]   nsec_r;

  logic                in_fire;
  logic                out_load;

  // Shared multiplier operands.
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;

  // Day count datapath.
  logic [Q100_W-1:0]   q100;
  logic                div100_exact;
  logic                is_leap;
  logic [11:0]         leaps_y;
  logic [3:0]          full_months;
  logic [YEAR_W-1:0]   year_off;
  logic [23:0]         year_days;
  logic [24:0]         day_sum;
  logic [TIME_W-1:0]   days;
  logic [17:0]         hms;

  assign in_ready    = (state_r == ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_time_ns = clock_r;
  assign out_load    = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_r)
      ST_DIV: begin
        mul_a = MUL_A_W'(year_r);
        mul_b = MUL_B_W'(DIV100_MUL);
      end
      ST_SLO: begin
        mul_a = x_r[31:0];
        mul_b = MUL_B_W'(SEC_PER_DAY);
      end
      ST_SHI: begin
        mul_a = x_r[63:32];
        mul_b = MUL_B_W'(SEC_PER_DAY);
      end
      ST_NLO: begin
        mul_a = x_r[31:0];
        mul_b = MUL_B_W'(NS_PER_SEC);
      end
      ST_NHI: begin
        mul_a = x_r[63:32];
        mul_b = MUL_B_W'(NS_PER_SEC);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Leap rules and whole days from the year quotient held in the product.
  always_comb begin
    q100         = prod_r[DIV100_SHIFT+Q100_W-1:DIV100_SHIFT];
    div100_exact = (year_r == YEAR_W'(q100) * YEAR_W'(100));
    is_leap      = (year_r[1:0] == 2'b00) && (!div100_exact || q100[1:0] == 2'b00);
    leaps_y      = 12'(year_r >> 2) - 12'(q100) + 12'(q100 >> 2);
    if (month_r == 4'd0) begin
      full_months = 4'd0;
    end else if (month_r > 4'd13) begin
      full_months = 4'd12;
    end else begin
      full_months = month_r - 4'd1;
    end
    year_off = year_r - YEAR_W'(EPOCH_YEAR);
    if (year_r > YEAR_W'(EPOCH_YEAR)) begin
      year_days = 24'(year_off) * 24'(DAYS_PER_YEAR) + 24'(leaps_y)
                - 24'(is_leap) - 24'(LEAPS_BEFORE_EPOCH);
    end else begin
      year_days = '0;
    end
    day_sum = 25'(year_days) + 25'(cum_days(full_months))
            + 25'(is_leap && (month_r > 4'd2)) + 25'(mday_r);
    // Day zero leaves minus one day, wrapping over 64 bits.
    days = TIME_W'(day_sum) - TIME_W'(1);
    hms  = 18'(hour_r) * 18'(SEC_PER_HOUR) + 18'(minute_r) * 18'(SEC_PER_MIN)
         + 18'(second_r);
  end

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    clock_nxt     = clock_r;
    period_nxt    = cfg_wr_en ? cfg_wr_data : period_r;
    prod_nxt      = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func) begin
            acc_nxt   = clock_r + TIME_W'(period_r);
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        state_nxt = ST_DAYS;
      end
      ST_DAYS: begin
        x_nxt     = days;
        acc_nxt   = TIME_W'(hms);
        state_nxt = ST_SLO;
      end
      ST_SLO: begin
        state_nxt = ST_SHI;
      end
      ST_SHI: begin
        acc_nxt   = acc_r + TIME_W'(prod_r);
        state_nxt = ST_SACC;
      end
      ST_SACC: begin
        // Seconds are complete; scale them next and seed with nanoseconds.
        x_nxt     = acc_r + {prod_r[31:0], 32'd0};
        acc_nxt   = TIME_W'(nsec_r);
        state_nxt = ST_NLO;
      end
      ST_NLO: begin
        state_nxt = ST_NHI;
      end
      ST_NHI: begin
        acc_nxt   = acc_r + TIME_W'(prod_r);
        state_nxt = ST_NACC;
      end
      ST_NACC: begin
        acc_nxt   = acc_r + {prod_r[31:0], 32'd0};
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          clock_nxt     = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and the clock itself.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      clock_r     <= '0;
      period_r    <= TICK_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clock_r     <= clock_nxt;
      period_r    <= period_nxt;
    end
  end

  // Working registers and captured load fields.
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
    if (in_fire) begin
      year_r   <= in_year;
      month_r  <= in_month;
      mday_r   <= in_day_of_month;
      hour_r   <= in_hour;
      minute_r <= in_minute;
      second_r <= in_second;
      nsec_r   <= in_nanosecond;
    end
  end

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking regression for calendar_epoch_clock
// Loads calendar dates and sends timer ticks through the valid/ready input,
// predicts the nanosecond clock after every beat and compares each output
// beat against it. Both channels idle and stall at random, and the tick
// period is reprogrammed between phases, including its extreme values.
// ============================================================================

module testbench;

  localparam int PERIOD_W = cec_pkg::PERIOD_W;
  localparam int YEAR_W   = cec_pkg::YEAR_W;
  localparam int NSEC_W   = cec_pkg::NSEC_W;

  // Calendar constants, kept independent of the design package.
  localparam int unsigned EPOCH          = 1970;
  localparam int unsigned YEAR_DAYS      = 365;
  localparam logic [63:0] NS_IN_SEC      = 64'd1_000_000_000;
  localparam logic [63:0] SEC_IN_DAY     = 64'd86_400;
  localparam logic [63:0] SEC_IN_HOUR    = 64'd3_600;
  localparam logic [63:0] SEC_IN_MIN     = 64'd60;
  localparam logic [PERIOD_W-1:0] PERIOD_AT_RESET = PERIOD_W'(100_000_000);
  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Cycles to let pass after the last result before touching the period.
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 100;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TICK = 1'b1
  } clock_func_e;

  typedef struct packed {
    clock_func_e                   func;
    logic [cec_pkg::YEAR_W-1:0]    year;
    logic [3:0]                    month;
    logic [4:0]                    mday;
    logic [4:0]                    hour;
    logic [5:0]                    minute;
    logic [5:0]                    second;
    logic [cec_pkg::NSEC_W-1:0]    nsec;
  } clock_beat_t;

  // Tracks the clock the block should hold and the results still owed.
  class clock_scoreboard;
    logic [63:0]         clock_ns;
    logic [PERIOD_W-1:0] tick_period;
    logic [63:0]         pending_time_ns[$];
    int unsigned         fail_count;

    function new();
      clock_ns    = '0;
      tick_period = PERIOD_AT_RESET;
      fail_count  = 0;
    endfunction

    function int unsigned leap_days_through(int unsigned n);
      return n / 4 - n / 100 + n / 400;
    endfunction

    // Nanoseconds since the epoch for a load beat, modulo 2^64.
    function logic [63:0] calendar_to_epoch_ns(clock_beat_t b);
      logic [63:0] days;
      logic [63:0] secs;
      int unsigned full_months;
      int unsigned y;
      int unsigned m;
      bit          leap;
      days        = 64'(b.mday) - 64'd1;
      full_months = (b.month == 4'd0) ? 0 : 32'(b.month) - 1;
      if (full_months > 12) full_months = 12;
      for (m = 0; m < full_months; m++) days += 64'(MONTH_LEN[m]);
      y    = 32'(b.year);
      leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
      if (leap && b.month > 4'd2) days += 64'd1;
      // Years before the epoch contribute no whole years.
      if (y > EPOCH) begin
        days += 64'(YEAR_DAYS) * 64'(y - EPOCH);
        days += 64'(leap_days_through(y - 1) - leap_days_through(EPOCH - 1));
      end
      secs = 64'(b.second) + 64'(b.minute) * SEC_IN_MIN + 64'(b.hour) * SEC_IN_HOUR
           + days * SEC_IN_DAY;
      return secs * NS_IN_SEC + 64'(b.nsec);
    endfunction

    function void note_input(clock_beat_t b);
      if (b.func == FUNC_LOAD) clock_ns = calendar_to_epoch_ns(b);
      else clock_ns = clock_ns + 64'(tick_period);
      pending_time_ns.push_back(clock_ns);
    endfunction

    task flag_mismatch(string what);
      if (fail_count < 40) $display("%0t: mismatch: %s", $realtime, what);
      fail_count++;
    endtask

    task check_result(logic [63:0] got);
      logic [63:0] want;
      if (pending_time_ns.size() == 0) begin
        flag_mismatch($sformatf("result 0x%016h with nothing pending", got));
      end else begin
        want = pending_time_ns.pop_front();
        if (got !== want)
          flag_mismatch($sformatf("time_ns 0x%016h, predicted 0x%016h", got, want));
      end
    endtask

    function int unsigned pending();
      return pending_time_ns.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  clock_beat_t         in_beat;
  logic                out_valid;
  logic                out_ready;
  logic [63:0]         out_time_ns;
  logic                cfg_wr_en;
  logic [PERIOD_W-1:0] cfg_wr_data;

  // While set, neither side idles.
  bit steady;

  clock_scoreboard sb;

  calendar_epoch_clock DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_beat.func),
    .in_year         (in_beat.year),
    .in_month        (in_beat.month),
    .in_day_of_month (in_beat.mday),
    .in_hour         (in_beat.hour),
    .in_minute       (in_beat.minute),
    .in_second       (in_beat.second),
    .in_nanosecond   (in_beat.nsec),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_time_ns     (out_time_ns),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Observe both channels on the edge; values read here are pre-edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_time_ns);
      if (in_valid && in_ready) sb.note_input(in_beat);
    end
  end

  // Result side backpressure: runs of ready and stalls, mostly short.
  initial begin
    int unsigned r;
    int unsigned len;
    forever begin
      if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) len = $urandom_range(1, 6);
        else if (r < 90) len = $urandom_range(1, 3);
        else if (r < 98) len = $urandom_range(4, 12);
        else len = $urandom_range(20, 60);
        out_ready <= (r < 50);
        repeat (len) @(posedge clk);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic clock_beat_t load_beat(int unsigned y, int unsigned mo, int unsigned d,
                                            int unsigned h, int unsigned mi, int unsigned s,
                                            int unsigned ns);
    clock_beat_t b;
    b.func   = FUNC_LOAD;
    b.year   = y[cec_pkg::YEAR_W-1:0];
    b.month  = mo[3:0];
    b.mday   = d[4:0];
    b.hour   = h[4:0];
    b.minute = mi[5:0];
    b.second = s[5:0];
    b.nsec   = ns[cec_pkg::NSEC_W-1:0];
    return b;
  endfunction

  // Mostly well-formed dates, with leap boundaries, the epoch edge and
  // raw field values mixed in. Ticks carry random junk in the date fields.
  function automatic clock_beat_t random_beat();
    clock_beat_t b;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) b.year = YEAR_W'($urandom_range(1900, 9999));
    else if (r < 75) b.year = YEAR_W'($urandom_range(19, 99) * 100 + $urandom_range(0, 2) - 1);
    else if (r < 85) b.year = YEAR_W'($urandom_range(1965, 1975));
    else b.year = YEAR_W'($urandom_range(0, 16383));
    b.month  = 4'(($urandom_range(0, 99) < 88) ? $urandom_range(1, 12) : $urandom_range(0, 15));
    b.mday   = 5'(($urandom_range(0, 99) < 90) ? $urandom_range(1, 31) : $urandom_range(0, 31));
    b.hour   = 5'(($urandom_range(0, 99) < 90) ? $urandom_range(0, 23) : $urandom_range(0, 31));
    b.minute = 6'(($urandom_range(0, 99) < 90) ? $urandom_range(0, 59) : $urandom_range(0, 63));
    b.second = 6'(($urandom_range(0, 99) < 90) ? $urandom_range(0, 59) : $urandom_range(0, 63));
    b.nsec   = NSEC_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 999_999_999)
                                                    : $urandom_range(0, 32'h3FFF_FFFF));
    b.func   = ($urandom_range(0, 99) < 45) ? FUNC_TICK : FUNC_LOAD;
    return b;
  endfunction

  // Present one beat, hold it until accepted, then maybe idle.
  task automatic send_beat(clock_beat_t b);
    int unsigned gap;
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every owed result has come out.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(logic [PERIOD_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    sb.tick_period  = value;
  endtask

  initial begin
    clock_beat_t         directed[$];
    clock_beat_t         tick;
    logic [PERIOD_W-1:0] periods[6];
    sb = new();
    steady       = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_beat     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset tick period.
    tick      = load_beat(16383, 15, 31, 31, 63, 63, 32'h3FFF_FFFF);
    tick.func = FUNC_TICK;
    directed.push_back(tick);                                          // tick from zero
    directed.push_back(load_beat(1970, 1, 1, 0, 0, 0, 0));             // the epoch
    directed.push_back(tick);
    directed.push_back(load_beat(1970, 1, 0, 23, 59, 59, 999_999_999)); // one ns short of 2^64
    directed.push_back(tick);                                          // wraps past 2^64
    directed.push_back(load_beat(16383, 15, 31, 31, 63, 63, 32'h3FFF_FFFF));
    directed.push_back(load_beat(0, 0, 0, 0, 0, 0, 0));                // day zero, year zero
    directed.push_back(load_beat(1969, 12, 31, 23, 59, 59, 999_999_999)); // before the epoch
    directed.push_back(load_beat(1900, 3, 1, 0, 0, 0, 0));             // century, not leap
    directed.push_back(load_beat(1971, 1, 1, 0, 0, 0, 0));
    directed.push_back(load_beat(1972, 2, 29, 12, 0, 0, 0));           // leap, still February
    directed.push_back(load_beat(1972, 3, 1, 0, 0, 0, 0));             // leap day counted
    directed.push_back(load_beat(2000, 2, 29, 23, 59, 59, 999_999_999));
    directed.push_back(load_beat(2000, 3, 1, 0, 0, 0, 1));
    directed.push_back(load_beat(2100, 3, 1, 0, 0, 0, 0));             // century, not leap
    directed.push_back(load_beat(2400, 3, 1, 0, 0, 0, 0));             // 400-year leap
    directed.push_back(load_beat(2024, 0, 15, 6, 30, 0, 0));           // month zero
    directed.push_back(load_beat(2024, 13, 1, 0, 0, 0, 0));            // months past December
    directed.push_back(load_beat(2023, 14, 1, 0, 0, 0, 0));
    directed.push_back(load_beat(2024, 6, 15, 12, 34, 56, 789_000_000));
    directed.push_back(load_beat(9999, 12, 31, 23, 59, 59, 999_999_999));
    directed.push_back(tick);
    directed.push_back(tick);
    foreach (directed[i]) send_beat(directed[i]);
    settle();

    // Random phases, each at its own tick period, extremes included.
    periods[0] = PERIOD_W'(1);
    periods[1] = PERIOD_W'(1_000_000_000);
    periods[2] = '0;                          // ticks leave the clock unchanged
    periods[3] = '1;
    periods[4] = PERIOD_W'($urandom_range(1, 1_000_000_000));
    periods[5] = PERIOD_AT_RESET;
    foreach (periods[p]) begin
      write_period(periods[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        steady = (i < 20) && (p % 2 == 1);
        send_beat(random_beat());
        // Let the block run dry midway through each phase.
        if (i == PHASE_ITEMS / 2) settle();
      end
      steady = 1'b0;
      settle();
    end

    if (sb.fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* calendar_epoch_clock.f */
hdl/cec_pkg.sv
hdl/calendar_epoch_clock.sv
test/testbench.sv
